// File: src/calc_port_interrupt_timer_ctrl_assert.svh
// Assertion shorthands for the port block checker.
// Both sample on clk and are disabled while rst is high.
`ifndef CALC_PORT_INTERRUPT_TIMER_CTRL_ASSERT_SVH
`define CALC_PORT_INTERRUPT_TIMER_CTRL_ASSERT_SVH

// Same-cycle implication.
`define CPIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CPIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/cpit_pkg.sv
package cpit_pkg;

  // Timer granule is a power of two: period = (sel + 1) << TICK_SHIFT.
  // TICK_SHIFT stays at 14 or below so that the period fits PERIOD_W bits.
  localparam int TICK_SHIFT   = 8;
  localparam int TICK_UNIT    = 1 << TICK_SHIFT;
  localparam int PERIOD_W     = 17;
  localparam int MAX_CONTRAST = 40;

  localparam logic [15:0] TICK_LOW_MASK  = 16'(TICK_UNIT - 1);
  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;
  localparam logic [1:0]  PERIOD_SEL_RST = 2'd3;
  localparam logic [4:0]  CONTRAST_TOP   = 5'((MAX_CONTRAST - 1) & 'h1F);
  localparam logic [6:0]  CONTRAST_LIMIT = 7'(MAX_CONTRAST);

  // Item kinds
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // Port numbers
  localparam logic [2:0] PORT_SCREEN   = 3'd0;
  localparam logic [2:0] PORT_CONTRAST = 3'd2;
  localparam logic [2:0] PORT_STATUS   = 3'd3;
  localparam logic [2:0] PORT_TIMER    = 3'd4;

  localparam logic [15:0] SCREEN_ORIGIN = 16'hE000;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] port;
    logic [7:0] wdata;
    logic       on_key;
  } item_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        irq;
    logic        lcd_on;
    logic [7:0]  lcd_width;
    logic [15:0] screen_base;
    logic [4:0]  contrast_level;
  } result_t;

  // Control decoded for the timer by the port logic
  typedef struct packed {
    logic       tick;
    logic       load;
    logic [1:0] sel;
    logic       wrap_en;
  } tmr_ctl_t;

  // Timer status back to the port logic
  typedef struct packed {
    logic expired;
    logic wrap;
  } tmr_stat_t;

endpackage

// File: src/cpit_timer.sv
module cpit_timer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  cpit_pkg::tmr_ctl_t   ctl,
  output cpit_pkg::tmr_stat_t  stat
);
  import cpit_pkg::*;

  logic [15:0] elapsed_ticks, elapsed_next;
  logic [1:0]  period_sel, period_sel_next;
  logic [15:0] ticked, less1, quo, wrapped;
  logic [1:0]  rem;

  function automatic logic [PERIOD_W-1:0] period_of(input logic [1:0] sel);
    logic [PERIOD_W-1:0] p;
    p = (PERIOD_W'(sel) + PERIOD_W'(1)) << TICK_SHIFT;
    return p;
  endfunction

  // Remainder by three: base-4 digits each weigh 1 mod 3.
  function automatic logic [1:0] mod3(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [1:0] r;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    case (t)
      3'd0, 3'd3, 3'd6: r = 2'd0;
      3'd1, 3'd4, 3'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  always_comb begin
    period_sel_next = ctl.load ? ctl.sel : period_sel;
    if (ctl.load) begin
      ticked = '0;
    end else if (ctl.tick && elapsed_ticks != ELAPSED_MAX) begin
      ticked = elapsed_ticks + 16'd1;
    end else begin
      ticked = elapsed_ticks;
    end

    stat.expired = {1'b0, elapsed_ticks} > period_of(period_sel);
    stat.wrap    = ctl.wrap_en && ({1'b0, ticked} > period_of(period_sel_next));

    // ((t - 1) mod period) + 1, period = k << TICK_SHIFT
    less1 = ticked - 16'd1;
    quo   = less1 >> TICK_SHIFT;
    case (period_sel_next)
      2'd0:    rem = 2'd0;
      2'd1:    rem = {1'b0, quo[0]};
      2'd2:    rem = mod3(quo);
      default: rem = quo[1:0];
    endcase
    wrapped      = ((16'(rem) << TICK_SHIFT) | (less1 & TICK_LOW_MASK)) + 16'd1;
    elapsed_next = stat.wrap ? wrapped : ticked;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ticks <= '0;
      period_sel    <= PERIOD_SEL_RST;
    end else if (fire) begin
      elapsed_ticks <= elapsed_next;
      period_sel    <= period_sel_next;
    end
  end

endmodule

// File: src/cpit_ports.sv
module cpit_ports (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  cpit_pkg::item_t      item,
  input  cpit_pkg::tmr_stat_t  stat,
  output cpit_pkg::tmr_ctl_t   tmr,
  output cpit_pkg::result_t    res
);
  import cpit_pkg::*;

  logic [2:0] int_mask, int_mask_next;
  logic       on_latched, on_latched_next;
  logic       on_prev;
  logic       lcd_active, lcd_active_next;
  logic [1:0] width_mode, width_mode_next;
  logic [4:0] screen_offset, screen_offset_next;
  logic [4:0] contrast_reg, contrast_reg_next;
  logic       is_wr, is_status_rd;
  logic       latch_kept, key_rise;

  always_comb begin
    is_wr        = item.func == FUNC_WRITE;
    is_status_rd = item.func == FUNC_READ && item.port == PORT_STATUS;

    screen_offset_next = (is_wr && item.port == PORT_SCREEN) ? item.wdata[4:0]
                                                             : screen_offset;
    contrast_reg_next = contrast_reg;
    if (is_wr && item.port == PORT_CONTRAST) begin
      contrast_reg_next = ({2'b00, item.wdata[4:0]} >= CONTRAST_LIMIT) ? CONTRAST_TOP
                                                                       : item.wdata[4:0];
    end

    lcd_active_next = lcd_active;
    int_mask_next   = int_mask;
    latch_kept      = on_latched;
    if (is_wr && item.port == PORT_STATUS) begin
      lcd_active_next = item.wdata[3];
      int_mask_next   = {item.wdata[2], 1'b0, item.wdata[0]};
      latch_kept      = on_latched && item.wdata[0];
    end

    width_mode_next = (is_wr && item.port == PORT_TIMER) ? item.wdata[4:3] : width_mode;

    tmr.tick    = item.func == FUNC_TICK;
    tmr.load    = is_wr && item.port == PORT_TIMER;
    tmr.sel     = item.wdata[2:1];
    tmr.wrap_en = !int_mask_next[2] && lcd_active_next;

    key_rise        = int_mask_next[0] && item.on_key && !on_prev;
    on_latched_next = latch_kept || key_rise;

    // status: bit 3 no latch, bit 2 expired, bit 1 lcd, bit 0 latch
    res.rdata = is_status_rd ? {4'b0000, !on_latched, stat.expired, lcd_active, on_latched}
                             : 8'h00;
    res.irq    = stat.wrap || on_latched_next;
    res.lcd_on = lcd_active_next;
    case (width_mode_next)
      2'd0:    res.lcd_width = 8'd80;
      2'd1:    res.lcd_width = 8'd96;
      2'd2:    res.lcd_width = 8'd128;
      default: res.lcd_width = 8'd160;
    endcase
    res.screen_base    = SCREEN_ORIGIN | {3'b000, screen_offset_next, 8'h00};
    res.contrast_level = contrast_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_mask      <= '0;
      on_latched    <= 1'b0;
      on_prev       <= 1'b0;
      lcd_active    <= 1'b0;
      width_mode    <= '0;
      screen_offset <= '0;
      contrast_reg  <= '0;
    end else if (fire) begin
      int_mask      <= int_mask_next;
      on_latched    <= on_latched_next;
      on_prev       <= item.on_key;
      lcd_active    <= lcd_active_next;
      width_mode    <= width_mode_next;
      screen_offset <= screen_offset_next;
      contrast_reg  <= contrast_reg_next;
    end
  end

endmodule

// File: src/calc_port_interrupt_timer_ctrl.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------
// item     | item_valid / item_stall    | func, port, wdata, on_key
// result   | result_valid / result_stall| rdata, irq, lcd_on, lcd_width,
//          |                            | screen_base, contrast_level
//
// One request per clock sustained while result_stall is low; result_valid rises
// once the request has passed the input register, then the result register.
// rst (synchronous) empties both registers; period selector resets to 3,
// all other port state to zero.
// A stalled result holds; item_stall rises only when the input register is
// full and the result register cannot drain in the same cycle.
module calc_port_interrupt_timer_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  cpit_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output cpit_pkg::result_t result
);
  import cpit_pkg::*;

  // Input stage
  item_t     item_q;
  logic      item_q_valid;

  // Result stage can load when empty or being taken this cycle
  logic      result_load;
  logic      fire;

  tmr_ctl_t  tmr_ctl;
  tmr_stat_t tmr_stat;
  result_t   result_next;

  assign result_load = !result_valid || !result_stall;
  assign fire        = item_q_valid && result_load;
  assign item_stall  = item_q_valid && !result_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

  // Timer: elapsed tick count, period select, expiry and wrap-around.
  // State update and result come from one pass of logic between the two
  // registers, so each request sees everything left by the one before it.
  cpit_timer u_timer (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .ctl  (tmr_ctl),
    .stat (tmr_stat)
  );

  // Port decode, display/interrupt registers, on-key latch, result build
  cpit_ports u_ports (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item_q),
    .stat (tmr_stat),
    .tmr  (tmr_ctl),
    .res  (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= item_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

endmodule

// File: src/cpit_checker.sv
`include "calc_port_interrupt_timer_ctrl_assert.svh"

module cpit_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input cpit_pkg::result_t result
);
  import cpit_pkg::*;

  `CPIT_ASSERT_NEXT(a_hold_valid, result_valid && result_stall, result_valid, "result dropped while stalled")
  `CPIT_ASSERT_NEXT(a_hold_data, result_valid && result_stall, $stable(result), "stalled result changed")
  `CPIT_ASSERT_NEXT(a_flow, (item_valid && !item_stall) ##1 !result_stall, result_valid, "accepted request produced no result")
  `CPIT_ASSERT_NOW(a_latch_irq, result_valid && result.rdata[0], result.irq, "latched on key without interrupt")
  `CPIT_ASSERT_NOW(a_base, result_valid, result.screen_base[15:13] == 3'b111 && result.screen_base[7:0] == 8'h00, "screen base off grid")

endmodule

bind calc_port_interrupt_timer_ctrl cpit_checker u_cpit_checker (.*);
